### hdl/dmcs_pkg.sv
// Shared types and constants of the minimum-cost dictionary segmenter.
// Used by the front queue, the back engine and the top level.
`default_nettype none

package dmcs_pkg;

    localparam int MAX_WORD_LEN_DEFAULT = 8;
    localparam int DICT_ENTRIES_DEFAULT = 1024;

    localparam int HIST_DEPTH  = 8;
    localparam int INDEX_W     = 10;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int WEIGHT_W    = 32;
    localparam int SYMBOL_W    = 8;
    localparam int COST_W      = 40;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 48;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SYMBOL = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [INDEX_W-1:0]    entry_index;
        logic [KEY_W-1:0]      entry_key;
        logic [LEN_W-1:0]      entry_length;
        logic [WEIGHT_W-1:0]   entry_weight;
        logic [SYMBOL_W-1:0]   symbol;
        logic                  last;
    } item_t;

    // Head of the item queue as seen by the back engine.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [LEN_W-1:0]    length;
        logic [KEY_W-1:0]    key;
    } dict_entry_t;

endpackage

`default_nettype wire

### hdl/dmcs_front.sv
// Front end: unpacks the input stream and buffers items in a two-entry queue.
// Depends on dmcs_pkg.
`default_nettype none

module dmcs_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          init_done,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dmcs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    output dmcs_pkg::queue_head_t              q_head,
    input  wire logic                          q_pop
);

    dmcs_pkg::item_t  in_item;
    dmcs_pkg::item_t  slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    always_comb begin
        in_item.func         = s_tuser;
        in_item.entry_index  = s_tdata[9:0];
        in_item.entry_key    = s_tdata[73:10];
        in_item.entry_length = s_tdata[77:74];
        in_item.entry_weight = s_tdata[109:78];
        in_item.symbol       = s_tdata[117:110];
        in_item.last         = s_tlast;
    end

    assign s_tready     = init_done && (count_reg != 2'd2);
    assign push         = s_tvalid && s_tready;
    assign pop          = q_pop && (count_reg != 2'd0);
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

### hdl/dmcs_back.sv
// Back end: dictionary memory, scan over all slots, best-cost selection
// and the output register. Depends on dmcs_pkg.
`default_nettype none

module dmcs_back #(
    parameter int MAX_WORD_LEN = dmcs_pkg::MAX_WORD_LEN_DEFAULT,
    parameter int DICT_ENTRIES = dmcs_pkg::DICT_ENTRIES_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [dmcs_pkg::LEN_W-1:0]    active_max_len,
    output logic                               init_done,
    input  wire dmcs_pkg::queue_head_t         q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dmcs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam logic [AW:0] SCAN_END = (AW+1)'(DICT_ENTRIES);
    localparam logic [PW-1:0] PICK_END = PW'(MAX_WORD_LEN - 1);
    localparam logic [dmcs_pkg::LEN_W-1:0] MAX_LEN = dmcs_pkg::LEN_W'(MAX_WORD_LEN);
    localparam logic [dmcs_pkg::LEN_W-1:0] POS_SAT = dmcs_pkg::LEN_W'(dmcs_pkg::HIST_DEPTH);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_PICK, ST_EMIT} state_t;

    dmcs_pkg::dict_entry_t mem [DICT_ENTRIES];
    dmcs_pkg::dict_entry_t rdata_reg;

    state_t                          state_reg;
    logic [AW:0]                     cnt_reg;
    logic                            cmp_valid_reg;
    logic [PW-1:0]                   pick_reg;
    logic [63:0]                     sym_hist_reg;
    logic [dmcs_pkg::COST_W-1:0]     cost_hist_reg [dmcs_pkg::HIST_DEPTH];
    logic [dmcs_pkg::LEN_W-1:0]      pos_reg;
    logic                            failed_reg;
    logic                            last_reg;
    logic [MAX_WORD_LEN-1:0]         found_reg;
    logic [dmcs_pkg::WEIGHT_W-1:0]   wt_reg [MAX_WORD_LEN];
    logic [dmcs_pkg::COST_W-1:0]     best_reg;
    logic [dmcs_pkg::LEN_W-1:0]      best_len_reg;
    logic                            out_valid_reg;
    logic [dmcs_pkg::COST_W-1:0]     out_cost_reg;
    logic [dmcs_pkg::LEN_W-1:0]      out_len_reg;
    logic                            out_nomatch_reg;
    logic                            out_last_reg;

    logic [dmcs_pkg::LEN_W-1:0]      eff_max;
    logic [dmcs_pkg::LEN_W:0]        pos_plus1;
    logic                            issuing;
    logic [MAX_WORD_LEN-1:0]         hit;
    logic [31:0]                     idx_ext;
    logic                            load_wr;
    logic [dmcs_pkg::LEN_W-1:0]      pick_len;
    logic [dmcs_pkg::COST_W-1:0]     left_cost;
    logic [dmcs_pkg::COST_W:0]       sum;
    logic [dmcs_pkg::COST_W-1:0]     total;
    logic                            out_free;

    assign eff_max   = (active_max_len > MAX_LEN) ? MAX_LEN : active_max_len;
    assign pos_plus1 = {1'b0, pos_reg} + 5'd1;
    assign issuing   = (state_reg == ST_SCAN) && (cnt_reg < SCAN_END);
    assign idx_ext   = 32'(q_head.item.entry_index);
    assign load_wr   = (state_reg == ST_IDLE) && q_head.valid
                       && (q_head.item.func == dmcs_pkg::FUNC_LOAD)
                       && (idx_ext < 32'(DICT_ENTRIES));
    assign init_done = (state_reg != ST_CLEAR);
    assign q_pop     = (state_reg == ST_IDLE) && q_head.valid;
    assign out_free  = !out_valid_reg || m_tready;

    // One comparator per word length; an entry holds one length, so at most one hits.
    always_comb begin
        logic [63:0] mask;
        logic [63:0] word;
        for (int l = 1; l <= MAX_WORD_LEN; l++) begin
            mask = (l >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << (8 * l)) - 64'd1);
            word = sym_hist_reg >> (64 - 8 * l);
            hit[l-1] = cmp_valid_reg && !found_reg[l-1]
                       && (rdata_reg.length == dmcs_pkg::LEN_W'(l))
                       && (dmcs_pkg::LEN_W'(l) <= eff_max)
                       && ((dmcs_pkg::LEN_W+1)'(l) <= pos_plus1)
                       && ((rdata_reg.key & mask) == word);
        end
    end

    assign pick_len  = dmcs_pkg::LEN_W'(pick_reg) + 4'd1;
    assign left_cost = ({1'b0, pick_len} == pos_plus1) ? '0 : cost_hist_reg[3'(pick_reg)];
    assign sum       = {1'b0, left_cost} + (dmcs_pkg::COST_W+1)'(wt_reg[pick_reg]);
    assign total     = sum[dmcs_pkg::COST_W] ? '1 : sum[dmcs_pkg::COST_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            mem[cnt_reg[AW-1:0]] <= '0;
        end else if (load_wr) begin
            mem[idx_ext[AW-1:0]] <= '{weight: q_head.item.entry_weight,
                                      length: q_head.item.entry_length,
                                      key:    q_head.item.entry_key};
        end
        rdata_reg <= mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            pick_reg      <= '0;
            sym_hist_reg  <= '0;
            for (int k = 0; k < dmcs_pkg::HIST_DEPTH; k++) begin
                cost_hist_reg[k] <= '0;
            end
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            last_reg      <= 1'b0;
            found_reg     <= '0;
            best_reg      <= '0;
            best_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // In ST_EMIT the output register is reloaded below whenever it is free.
            if (out_valid_reg && m_tready && state_reg != ST_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            cmp_valid_reg <= issuing;
            for (int l = 0; l < MAX_WORD_LEN; l++) begin
                if (hit[l]) begin
                    found_reg[l] <= 1'b1;
                    wt_reg[l]    <= rdata_reg.weight;
                end
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (cnt_reg == SCAN_END - 1'b1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (q_head.valid && q_head.item.func == dmcs_pkg::FUNC_SYMBOL) begin
                        if (failed_reg) begin
                            if (q_head.item.last) begin
                                sym_hist_reg <= '0;
                                for (int k = 0; k < dmcs_pkg::HIST_DEPTH; k++) begin
                                    cost_hist_reg[k] <= '0;
                                end
                                pos_reg    <= '0;
                                failed_reg <= 1'b0;
                            end
                        end else begin
                            sym_hist_reg <= {q_head.item.symbol, sym_hist_reg[63:8]};
                            last_reg     <= q_head.item.last;
                            found_reg    <= '0;
                            cnt_reg      <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (issuing) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else if (!cmp_valid_reg) begin
                        pick_reg     <= '0;
                        best_len_reg <= '0;
                        best_reg     <= '0;
                        state_reg    <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    // Lengths are visited in rising order, so a tie keeps the shorter word.
                    if (found_reg[pick_reg] && (best_len_reg == '0 || total < best_reg)) begin
                        best_reg     <= total;
                        best_len_reg <= pick_len;
                    end
                    if (pick_reg == PICK_END) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        pick_reg <= pick_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg   <= 1'b1;
                        out_last_reg    <= last_reg;
                        out_nomatch_reg <= (best_len_reg == '0);
                        out_len_reg     <= best_len_reg;
                        out_cost_reg    <= best_reg;
                        state_reg       <= ST_IDLE;
                        if (last_reg) begin
                            sym_hist_reg <= '0;
                            for (int k = 0; k < dmcs_pkg::HIST_DEPTH; k++) begin
                                cost_hist_reg[k] <= '0;
                            end
                            pos_reg    <= '0;
                            failed_reg <= 1'b0;
                        end else if (best_len_reg == '0) begin
                            failed_reg <= 1'b1;
                        end else begin
                            for (int k = dmcs_pkg::HIST_DEPTH - 1; k > 0; k--) begin
                                cost_hist_reg[k] <= cost_hist_reg[k-1];
                            end
                            cost_hist_reg[0] <= best_reg;
                            if (pos_reg < POS_SAT) begin
                                pos_reg <= pos_reg + 4'd1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_len_reg, out_cost_reg};
    assign m_tuser  = out_nomatch_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hdl/dictionary_min_cost_segmenter.sv
// Minimum-cost dictionary segmenter. Loads stream at one item per cycle while the back end
// is idle. A symbol item holds the back end through a scan that reads one dictionary slot per
// cycle from the single read port, then one add and compare per word length; its result is
// then loaded into the output register once that register is free. After reset a clearing
// pass writes zero to every dictionary slot; items wait, configuration writes do not.
// Depends on dmcs_pkg.
`default_nettype none

module dictionary_min_cost_segmenter #(
    parameter int MAX_WORD_LEN = dmcs_pkg::MAX_WORD_LEN_DEFAULT,
    parameter int DICT_ENTRIES = dmcs_pkg::DICT_ENTRIES_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [3:0]                     cfg_data,    // active_max_len
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, entry_key, entry_length, entry_weight, symbol, zero fill
    input  wire logic [dmcs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,     // func
    input  wire logic                           s_tlast,     // last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dmcs_pkg::M_TDATA_W-1:0]      m_tdata,     // best_cost, best_length, zero fill
    output logic                                m_tuser,     // no_match
    output logic                                m_tlast      // last_out
);

    logic [3:0]            max_len_reg;
    logic                  init_done;
    logic                  q_pop;
    dmcs_pkg::queue_head_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 4'd8;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    dmcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    dmcs_back #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .active_max_len (max_len_reg),
        .init_done      (init_done),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

`default_nettype wire

### verif/tb_dictionary_min_cost_segmenter.sv
// Self-checking testbench of the minimum-cost dictionary segmenter: directed and random streams of
// dictionary loads and symbol sequences are checked against an in-bench cost predictor.
// Depends on dmcs_pkg and dictionary_min_cost_segmenter.
`default_nettype none

module tb_dictionary_min_cost_segmenter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS     = dmcs_pkg::DICT_ENTRIES_DEFAULT;
    localparam int MAX_LEN     = dmcs_pkg::MAX_WORD_LEN_DEFAULT;
    localparam int DRAIN_WAIT  = N_SLOTS + MAX_LEN + 64;
    localparam logic [dmcs_pkg::COST_W-1:0] COST_SAT = {dmcs_pkg::COST_W{1'b1}};

    typedef struct packed {
        logic [dmcs_pkg::COST_W-1:0] best_cost;
        logic [dmcs_pkg::LEN_W-1:0]  best_length;
        logic                        no_match;
        logic                        last_out;
    } seg_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = 4'd8;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dmcs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dmcs_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    dictionary_min_cost_segmenter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Predictor state: dictionary copy, sequence history and the length register.
    logic [dmcs_pkg::KEY_W-1:0]    dict_key [N_SLOTS];
    logic [dmcs_pkg::LEN_W-1:0]    dict_len [N_SLOTS];
    logic [dmcs_pkg::WEIGHT_W-1:0] dict_wt  [N_SLOTS];
    logic [63:0]                   sym_hist;
    logic [dmcs_pkg::COST_W-1:0]   cost_hist [8];
    int unsigned                   seq_pos;
    bit                            seq_failed;
    logic [3:0]                    max_len_reg = 4'd8;

    dmcs_pkg::item_t pending_items[$];
    seg_result_t     expected_results[$];
    int              error_count = 0;
    bit              quiet = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void clear_sequence();
        sym_hist = '0;
        for (int k = 0; k < 8; k++) cost_hist[k] = '0;
        seq_pos = 0;
        seq_failed = 1'b0;
    endfunction

    function automatic void predict_segment(dmcs_pkg::item_t it);
        int unsigned lim;
        logic [dmcs_pkg::COST_W-1:0] best, left, total;
        logic [63:0] word, mask;
        int best_len;
        int hit;
        seg_result_t r;
        if (it.func == dmcs_pkg::FUNC_LOAD) begin
            dict_key[it.entry_index] = it.entry_key;
            dict_len[it.entry_index] = it.entry_length;
            dict_wt[it.entry_index]  = it.entry_weight;
            return;
        end
        if (seq_failed) begin
            if (it.last) clear_sequence();
            return;
        end
        sym_hist = {it.symbol, sym_hist[63:8]};
        lim = (max_len_reg > MAX_LEN) ? MAX_LEN : max_len_reg;
        best = '0;
        best_len = 0;
        for (int unsigned len = 1; len <= lim; len++) begin
            if (len > seq_pos + 1) break;
            word = sym_hist >> (64 - 8 * len);
            mask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 1);
            hit = -1;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (dict_len[i] == len && (dict_key[i] & mask) == word) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) continue;
            left = (len == seq_pos + 1) ? '0 : cost_hist[len - 1];
            total = left + dict_wt[hit];
            if (total < left) total = COST_SAT;
            if (best_len == 0 || total < best) begin
                best = total;
                best_len = len;
            end
        end
        r.last_out = it.last;
        if (best_len == 0) begin
            r.best_cost = '0;
            r.best_length = '0;
            r.no_match = 1'b1;
            if (it.last) clear_sequence();
            else seq_failed = 1'b1;
        end else begin
            r.best_cost = best;
            r.best_length = best_len[dmcs_pkg::LEN_W-1:0];
            r.no_match = 1'b0;
            if (it.last) begin
                clear_sequence();
            end else begin
                for (int k = 7; k > 0; k--) cost_hist[k] = cost_hist[k - 1];
                cost_hist[0] = best;
                if (seq_pos < 8) seq_pos++;
            end
        end
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Input driver.
    int              send_wait = 0;
    dmcs_pkg::item_t cur_item;
    always @(posedge aclk) begin : drive_items
        logic next_valid;
        next_valid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_segment(cur_item);
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {2'b0, cur_item.symbol, cur_item.entry_weight,
                                cur_item.entry_length, cur_item.entry_key,
                                cur_item.entry_index};
                    s_tuser <= cur_item.func;
                    s_tlast <= cur_item.last;
                    next_valid = 1'b1;
                    send_wait = pick_gap();
                end
            end
        end
        s_tvalid <= next_valid;
    end

    // Result monitor with random back-pressure.
    int stall_wait = 0;
    always @(posedge aclk) begin : check_results
        seg_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[dmcs_pkg::COST_W-1:0] !== want.best_cost)
                        report_mismatch("best_cost", m_tdata[dmcs_pkg::COST_W-1:0],
                                        want.best_cost);
                    if (m_tdata[dmcs_pkg::COST_W+dmcs_pkg::LEN_W-1:dmcs_pkg::COST_W]
                        !== want.best_length)
                        report_mismatch("best_length",
                                        m_tdata[dmcs_pkg::COST_W+dmcs_pkg::LEN_W-1:
                                                dmcs_pkg::COST_W],
                                        want.best_length);
                    if (m_tuser !== want.no_match)
                        report_mismatch("no_match", m_tuser, want.no_match);
                    if (m_tlast !== want.last_out)
                        report_mismatch("last_out", m_tlast, want.last_out);
                end
            end
            if (stall_wait > 0) begin
                stall_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_wait = pick_gap();
            end
        end
    end

    function automatic void push_load(int idx, logic [63:0] key, int len, logic [31:0] wt);
        dmcs_pkg::item_t it;
        it = '0;
        it.func = dmcs_pkg::FUNC_LOAD;
        it.entry_index = idx[dmcs_pkg::INDEX_W-1:0];
        it.entry_key = key;
        it.entry_length = len[dmcs_pkg::LEN_W-1:0];
        it.entry_weight = wt;
        it.symbol = 8'($urandom());
        it.last = 1'($urandom_range(0, 1));
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void push_symbol(logic [7:0] sym, bit last);
        dmcs_pkg::item_t it;
        it.func = dmcs_pkg::FUNC_SYMBOL;
        it.entry_index = 10'($urandom());
        it.entry_key = {$urandom(), $urandom()};
        it.entry_length = 4'($urandom());
        it.entry_weight = $urandom();
        it.symbol = sym;
        it.last = last;
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Key of letters from a small alphabet, junk above the word.
    function automatic logic [63:0] letter_key(int len);
        logic [63:0] k;
        k = {$urandom(), $urandom()};
        for (int b = 0; b < len && b < 8; b++) k[8*b +: 8] = 8'(8'h61 + $urandom_range(0, 3));
        return k;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [3:0] v);
        @(posedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len_reg = v;
    endtask

    initial begin : stimulus
        int phase_items;
        int n, len;
        logic [3:0] settings[10];
        settings = '{4'd1, 4'd3, 4'd8, 4'd5, 4'd2, 4'd8, 4'd6, 4'd4, 4'd7, 4'd8};
        for (int i = 0; i < N_SLOTS; i++) begin
            dict_len[i] = '0;
            dict_key[i] = '0;
            dict_wt[i] = '0;
        end
        clear_sequence();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_max_len(4'd8);

        // Directed: extreme slots and weights, duplicate, over-long and empty entries.
        push_load(1023, 64'hFFFF_FFFF_FFFF_FF61, 1, 32'h0001_0000);
        push_load(0, 64'hA5A5_A5A5_A5A5_6261, 2, 32'h0001_8000);
        push_load(5, 64'h0000_0000_0000_6261, 2, 32'h0000_0001);
        push_load(7, 64'h6162_6162_6162_6162, 9, 32'h0000_0000);
        push_load(8, 64'h0000_0000_0000_0062, 1, 32'hFFFF_FFFF);
        push_load(9, 64'h6261_6261_6261_6261, 8, 32'h0000_0000);
        push_load(10, 64'h0000_0000_0000_0063, 0, 32'h0000_0001);
        for (int i = 0; i < 8; i++) push_symbol((i % 2) ? 8'h62 : 8'h61, i == 7);
        push_symbol(8'h63, 1'b0);
        push_symbol(8'h61, 1'b0);
        push_symbol(8'h62, 1'b0);
        push_symbol(8'h61, 1'b1);
        push_symbol(8'h63, 1'b1);
        push_symbol(8'h61, 1'b1);
        wait_idle();

        // Cost saturation: a long run of the heaviest single-symbol word.
        push_load(11, 64'h0000_0000_0000_007A, 1, 32'hFFFF_FFFF);
        for (int i = 0; i < 260; i++) push_symbol(8'h7A, i == 259);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            write_max_len(settings[p]);
            quiet = (p % 3 == 2);
            phase_items = 0;
            // Loading each letter, most of the time, as a single-symbol word keeps most sequences alive.
            for (int c = 0; c < 4; c++) begin
                if ($urandom_range(0, 9) != 0) begin
                    push_load(12 + c, 64'h61 + c, 1, $urandom_range(0, 32'h0004_0000));
                    phase_items++;
                end
            end
            while (phase_items < 44) begin
                n = $urandom_range(0, 99);
                if (n < 20) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(2, 4);
                    push_load($urandom_range(16, 80), letter_key(len), len,
                              ($urandom_range(0, 7) == 0) ? $urandom()
                                                          : $urandom_range(0, 32'h0003_0000));
                    phase_items++;
                end else if (n < 26) begin
                    push_load($urandom_range(0, N_SLOTS - 1), {$urandom(), $urandom()},
                              $urandom_range(0, 15), $urandom());
                    phase_items++;
                end else begin
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 19) == 0)
                            push_symbol(8'($urandom()), i == len - 1);
                        else
                            push_symbol(8'(8'h61 + $urandom_range(0, 3)), i == len - 1);
                    end
                    phase_items += len;
                end
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #100ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/dmcs_pkg.sv
hdl/dmcs_front.sv
hdl/dmcs_back.sv
hdl/dictionary_min_cost_segmenter.sv
verif/tb_dictionary_min_cost_segmenter.sv
